// File: src/pcmf_pkg.sv
// ----------------------------------------------------------------------------
// PCM to float32 package
// Format codes, the reset format and pipeline stage payloads.
// ----------------------------------------------------------------------------
package pcmf_pkg;

  typedef enum logic [2:0] {
    FMT_PCM8  = 3'd0,
    FMT_PCM16 = 3'd1,
    FMT_PCM24 = 3'd2,
    FMT_PCM32 = 3'd3,
    FMT_F32   = 3'd4,
    FMT_F64   = 3'd5
  } sample_format_e;

  localparam logic [2:0] FormatReset = 3'd1;

  // Stage 1 to stage 2: classified sample.
  typedef struct packed {
    logic        is_int;    // integer PCM path
    logic        direct;    // result already final
    logic [31:0] direct_bits;
    logic        sign;
    logic [31:0] mag;       // integer magnitude
    logic [7:0]  scale;     // integer scale exponent
    logic        f64_norm;  // float64 normal result
    logic        f64_sub;   // float64 subnormal result
    logic [52:0] m53;
    logic [10:0] ex;
  } s1_t;

  // Stage 2 to stage 3: normalized mantissa with sticky information.
  typedef struct packed {
    logic        direct;
    logic [31:0] direct_bits;
    logic        sign;
    logic [23:0] m24;       // truncated mantissa
    logic        guard;
    logic        sticky;
    logic [8:0]  expm1;     // exponent minus one, or zero for subnormal
    logic        ovf_check;
  } s2_t;

endpackage

// File: src/pcmf_decode.sv
// ----------------------------------------------------------------------------
// PCM to float32 decode stage
// Extracts sign, magnitude and special cases for the selected format.
// ----------------------------------------------------------------------------
module pcmf_decode (
  input  logic [2:0]     sample_format_i,
  input  logic [63:0]    raw_i,
  output pcmf_pkg::s1_t  s1_o
);

  logic signed [32:0] v;
  logic [10:0]        ex;
  logic [51:0]        frac;

  always_comb begin
    s1_o      = '0;
    v         = '0;
    ex        = raw_i[62:52];
    frac      = raw_i[51:0];
    s1_o.ex   = ex;
    s1_o.m53  = {1'b1, frac};
    case (sample_format_i)
      pcmf_pkg::FMT_PCM8: begin
        v = 33'(signed'({1'b0, raw_i[7:0]})) - 33'sd128;
        s1_o.scale = 8'd7;
        s1_o.is_int = 1'b1;
      end
      pcmf_pkg::FMT_PCM16: begin
        v = 33'(signed'(raw_i[15:0]));
        s1_o.scale = 8'd15;
        s1_o.is_int = 1'b1;
      end
      pcmf_pkg::FMT_PCM24: begin
        v = 33'(signed'(raw_i[23:0]));
        s1_o.scale = 8'd23;
        s1_o.is_int = 1'b1;
      end
      pcmf_pkg::FMT_PCM32: begin
        v = 33'(signed'(raw_i[31:0]));
        s1_o.scale = 8'd31;
        s1_o.is_int = 1'b1;
      end
      pcmf_pkg::FMT_F32: begin
        s1_o.direct = 1'b1;
        s1_o.direct_bits = raw_i[31:0];
      end
      pcmf_pkg::FMT_F64: begin
        s1_o.sign = raw_i[63];
        if (ex == 11'h7FF) begin
          s1_o.direct = 1'b1;
          s1_o.direct_bits = (frac != '0)
            ? {raw_i[63], 8'hFF, 1'b1, frac[50:29]}
            : {raw_i[63], 31'h7F800000};
        end else if (ex == '0 || ex < 11'd842) begin
          // Zero, float64 subnormals and anything below 2**-181 flush to a signed
          // zero.
          s1_o.direct = 1'b1;
          s1_o.direct_bits = {raw_i[63], 31'd0};
        end else if (ex >= 11'd1151) begin
          s1_o.direct = 1'b1;
          s1_o.direct_bits = {raw_i[63], 31'h7F800000};
        end else if (ex >= 11'd897) begin
          s1_o.f64_norm = 1'b1;
        end else begin
          s1_o.f64_sub = 1'b1;
        end
      end
      default: begin
        s1_o.direct = 1'b1;
        s1_o.direct_bits = '0;
      end
    endcase
    if (s1_o.is_int) begin
      s1_o.sign = v[32];
      s1_o.mag  = v[32] ? 32'(-v) : v[31:0];
      if (v == '0) begin
        s1_o.direct = 1'b1;
        s1_o.direct_bits = '0;
      end
    end
  end

endmodule

// File: src/pcmf_normalize.sv
// ----------------------------------------------------------------------------
// PCM to float32 normalize stage
// Finds the leading one or the subnormal shift and forms guard and sticky.
// ----------------------------------------------------------------------------
module pcmf_normalize (
  input  pcmf_pkg::s1_t  s1_i,
  output pcmf_pkg::s2_t  s2_o
);

  logic [4:0]  p;
  logic [63:0] ext;
  logic [5:0]  sh;
  logic [116:0] wide;
  logic [10:0] s;

  always_comb begin
    s2_o             = '0;
    s2_o.direct      = s1_i.direct;
    s2_o.direct_bits = s1_i.direct_bits;
    s2_o.sign        = s1_i.sign;
    p    = '0;
    ext  = '0;
    sh   = '0;
    wide = '0;
    s    = '0;
    for (int i = 0; i < 32; i++) begin
      if (s1_i.mag[i]) p = 5'(i);
    end
    if (s1_i.is_int) begin
      // Place the leading one at bit 63, then the top 24 bits are m24.
      sh  = 6'(6'd63 - {1'b0, p});
      ext = {32'd0, s1_i.mag} << sh;
      s2_o.m24    = ext[63:40];
      s2_o.guard  = ext[39];
      s2_o.sticky = |ext[38:0];
      s2_o.expm1  = 9'({4'd0, p} + 9'd126 - {1'b0, s1_i.scale});
    end else if (s1_i.f64_norm) begin
      s2_o.m24    = s1_i.m53[52:29];
      s2_o.guard  = s1_i.m53[28];
      s2_o.sticky = |s1_i.m53[27:0];
      s2_o.expm1  = 9'(s1_i.ex - 11'd897);
      s2_o.ovf_check = 1'b1;
    end else if (s1_i.f64_sub) begin
      // Shift amount is 926 - ex, between 30 and 84; keep the bits in a
      // wide window so guard and sticky come out directly.
      s    = 11'd926 - s1_i.ex;
      wide = {s1_i.m53, 64'd0} >> s[6:0];
      s2_o.m24    = wide[87:64];
      s2_o.guard  = wide[63];
      s2_o.sticky = |wide[62:0];
      s2_o.expm1  = '0;
    end
  end

endmodule

// File: src/pcmf_round.sv
// ----------------------------------------------------------------------------
// PCM to float32 round stage
// Applies nearest-even rounding and assembles the result word.
// ----------------------------------------------------------------------------
module pcmf_round (
  input  pcmf_pkg::s2_t  s2_i,
  output logic [31:0]    bits_o
);

  logic        inc;
  logic [24:0] mr;
  logic [31:0] sum;

  always_comb begin
    inc = s2_i.guard & (s2_i.sticky | s2_i.m24[0]);
    mr  = {1'b0, s2_i.m24} + {24'd0, inc};
    // The mantissa carries its leading one into the exponent field, so a
    // rounding carry bumps the exponent on its own.
    sum = ({23'd0, s2_i.expm1} << 23) + {7'd0, mr};
    if (s2_i.ovf_check && sum[30:0] >= 31'h7F800000) sum = 32'h7F800000;
    if (s2_i.direct) begin
      bits_o = s2_i.direct_bits;
    end else begin
      bits_o = {s2_i.sign, sum[30:0]};
    end
  end

endmodule

// File: src/pcm_sample_to_float32.sv
// Throughput: one sample per cycle; decode, normalize and round are each
// one register stage, and a stall freezes all stages together.
// Reset clears the stage valid bits and sets sample_format to pcm16.
// ----------------------------------------------------------------------------
// PCM sample to float32
// Three-stage pipeline converting one PCM or float sample to binary32.
// ----------------------------------------------------------------------------
module pcm_sample_to_float32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] raw_sample_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] float_bits_o
);

  logic [2:0]    fmt_q;
  logic          v1_q, v2_q, v3_q;
  pcmf_pkg::s1_t s1_d, s1_q;
  pcmf_pkg::s2_t s2_d, s2_q;
  logic [31:0]   r_d, r_q;
  logic          adv;

  // The chain moves when the output stage is empty or being taken.
  assign adv        = !v3_q || !out_stall_i;
  assign in_stall_o = !adv;

  pcmf_decode u_dec (.sample_format_i(fmt_q), .raw_i(raw_sample_bytes_i), .s1_o(s1_d));
  pcmf_normalize u_norm (.s1_i(s1_q), .s2_o(s2_d));
  pcmf_round u_rnd (.s2_i(s2_q), .bits_o(r_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= pcmf_pkg::FormatReset;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (cfg_we_i) fmt_q <= cfg_wdata_i;
      if (adv) begin
        v1_q <= in_valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      r_q  <= r_d;
    end
  end

  assign out_valid_o  = v3_q;
  assign float_bits_o = r_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(float_bits_o))
    else $error("result changed under stall");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && v2_q |=> out_valid_o)
    else $error("stage two item lost");
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without cause");

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// PCM to float32 conversion testbench
// Drives raw sample bytes in every sample format through the converter and
// checks each result against a bit-exact predictor, with random idling on
// both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency = 3;
  localparam logic [2:0] FmtUnused6 = 3'd6;
  localparam logic [2:0] FmtUnused7 = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] raw_sample_bytes_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] float_bits_o;

  pcm_sample_to_float32 uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .raw_sample_bytes_i(raw_sample_bytes_i), .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i), .float_bits_o(float_bits_o)
  );

  always #4 clk_i = ~clk_i;

  logic [2:0]  fmt_model;
  logic [31:0] expected_floats[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned samples_sent = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holdoff_cycles = 0;

  // Shift right by s with round to nearest, ties to even.
  function automatic logic [63:0] round_shift(logic [63:0] m, int unsigned s);
    logic [63:0] q, rem, half;
    q = m >> s;
    rem = m & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Signed integer times 2^-scale as a binary32 pattern.
  function automatic logic [31:0] scaled_int_bits(longint v, int unsigned scale);
    logic [31:0] sgn;
    logic [63:0] mag, m24;
    int unsigned p;
    if (v == 0) return 32'd0;
    sgn = (v < 0) ? 32'h8000_0000 : 32'd0;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    p = 0;
    while (p < 63 && (mag >> (p + 1)) != 0) p++;
    m24 = (p <= 23) ? (mag << (23 - p)) : round_shift(mag, p - 23);
    return sgn + (32'(p + 126 - scale) << 23) + 32'(m24);
  endfunction

  function automatic logic [31:0] narrow_double(logic [63:0] d);
    logic [31:0] sgn, bits;
    logic [10:0] ex;
    logic [63:0] m;
    int e32;
    sgn = {d[63], 31'd0};
    ex = d[62:52];
    if (ex == 11'h7FF) begin
      if (d[51:0] != 0) return sgn | 32'h7FC0_0000 | 32'(d[51:0] >> 29);
      return sgn | 32'h7F80_0000;
    end
    if (ex == 0) return sgn;
    m = {11'd1, d[51:0]};
    e32 = int'(ex) - 896;
    if (e32 >= 255) return sgn | 32'h7F80_0000;
    if (e32 >= 1) begin
      bits = (32'(e32 - 1) << 23) + 32'(round_shift(m, 29));
      if (bits >= 32'h7F80_0000) bits = 32'h7F80_0000;
      return sgn | bits;
    end
    if (926 - int'(ex) >= 55) return sgn;
    return sgn | 32'(round_shift(m, 926 - int'(ex)));
  endfunction

  function automatic logic [31:0] converted_sample(logic [2:0] fmt, logic [63:0] raw);
    case (fmt)
      pcmf_pkg::FMT_PCM8:  return scaled_int_bits(longint'(raw[7:0]) - 128, 7);
      pcmf_pkg::FMT_PCM16: return scaled_int_bits(longint'($signed(raw[15:0])), 15);
      pcmf_pkg::FMT_PCM24: return scaled_int_bits(longint'($signed(raw[23:0])), 23);
      pcmf_pkg::FMT_PCM32: return scaled_int_bits(longint'($signed(raw[31:0])), 31);
      pcmf_pkg::FMT_F32:   return raw[31:0];
      pcmf_pkg::FMT_F64:   return narrow_double(raw);
      default:             return 32'd0;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off while holdoff_cycles is set.
  always @(posedge clk_i) begin
    if (holdoff_cycles != 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_floats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", float_bits_o);
      end else begin
        want = expected_floats.pop_front();
        if (want !== float_bits_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h, got %h", want, float_bits_o);
        end
      end
    end
  end

  // Valid stays high after a transfer; drain() or idling in the next call lowers it.
  task automatic send_sample(logic [63:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_sample_bytes_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_floats.push_back(converted_sample(fmt_model, raw));
    samples_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_floats.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_format(logic [2:0] fmt);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= fmt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fmt_model = fmt;
  endtask

  task automatic test_reset_format();
    send_sample(64'h0000_0000_0000_8000);
    send_sample(64'hFFFF_FFFF_FFFF_7FFF);
  endtask

  task automatic test_integer_extremes();
    write_format(pcmf_pkg::FMT_PCM8);
    send_sample(64'h0); send_sample(64'hFF); send_sample(64'h80);
    send_sample(64'hFFFF_FFFF_FFFF_FF7F);
    write_format(pcmf_pkg::FMT_PCM24);
    send_sample(64'h80_0000); send_sample(64'h7F_FFFF); send_sample(64'h1);
    write_format(pcmf_pkg::FMT_PCM32);
    send_sample(64'h8000_0000); send_sample(64'h7FFF_FFFF);
    send_sample(64'h0100_0001); send_sample(64'h0100_0003); send_sample(64'h0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_float_special_cases();
    write_format(pcmf_pkg::FMT_F32);
    send_sample(64'hDEAD_BEEF_7FC0_0001);
    write_format(pcmf_pkg::FMT_F64);
    send_sample(64'h7FF0_0000_0000_0000); send_sample(64'hFFF0_0000_0000_0000);
    send_sample(64'hFFF8_0000_0000_0001); send_sample(64'h7FF0_0000_2000_0000);
    send_sample(64'h47EF_FFFF_F000_0000); send_sample(64'h4800_0000_0000_0000);
    send_sample(64'h3690_0000_0000_0000); send_sample(64'hB680_0000_0000_0001);
    send_sample(64'h8000_0000_0000_0001); send_sample(64'h380F_FFFF_F000_0000);
    write_format(FmtUnused6);
    send_sample(64'h1234_5678_9ABC_DEF0);
    write_format(FmtUnused7);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Random raw bytes, biased toward interesting double exponents and a fixed PCM32 low-bit pattern.
  function automatic logic [63:0] random_raw(logic [2:0] fmt);
    logic [63:0] r;
    r = rand64();
    if (fmt == pcmf_pkg::FMT_F64 && $urandom_range(3) != 0)
      r[62:52] = 11'($urandom_range(860, 1160));
    if (fmt == pcmf_pkg::FMT_PCM32 && $urandom_range(3) == 0)
      r[4:0] = 5'h10;
    return r;
  endfunction

  task automatic test_random_formats(int unsigned count);
    logic [2:0] fmt;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        fmt = 3'($urandom_range(7));
        if (fmt > pcmf_pkg::FMT_F64 && $urandom_range(3) != 0) fmt = pcmf_pkg::FMT_F64;
        write_format(fmt);
      end
      send_sample(random_raw(fmt_model));
    end
  endtask

  task automatic test_output_holdoff();
    write_format(pcmf_pkg::FMT_PCM16);
    send_idle_pct = 0;
    holdoff_cycles = 60;
    for (int i = 0; i < 30; i++) send_sample(rand64());
    drain();
  endtask

  initial begin
    fmt_model = pcmf_pkg::FormatReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_format();
    test_integer_extremes();
    test_float_special_cases();
    send_idle_pct = 34; recv_idle_pct = 49;
    test_random_formats(150);
    send_idle_pct = 49; recv_idle_pct = 34;
    test_random_formats(150);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_formats(120);
    test_output_holdoff();
    drain();
    $display("Converted %0d samples (%0d results) across all eight format codes,",
             samples_sent, results_seen);
    $display("with random idling, a long output hold-off and drain pauses.");
    if (mismatches == 0 && expected_floats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_floats.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/pcmf_pkg.sv
src/pcmf_decode.sv
src/pcmf_normalize.sv
src/pcmf_round.sv
src/pcm_sample_to_float32.sv
dv/testbench.sv
